// File: sv/rsub_pkg.sv
// ----------------------------------------------------------------------------
// rsub_pkg
// Shared types and field widths for the subresource range subtract block.
// ----------------------------------------------------------------------------
package rsub_pkg;

    // Field widths
    localparam int LB_W   = 11;   // layer base
    localparam int LC_W   = 12;   // layer count
    localparam int MB_W   = 4;    // mip base
    localparam int MC_W   = 5;    // mip count
    localparam int ASP_W  = 4;    // aspect mask

    // Widths that hold base + count exactly
    localparam int LSUM_W = 13;
    localparam int MSUM_W = 6;

    // Up to five pieces per item
    localparam int MAX_PIECES = 5;
    localparam int PCNT_W     = 3;

    // Input transaction
    typedef struct packed {
        logic [LB_W-1:0]  src_layer_base;
        logic [LC_W-1:0]  src_layer_count;
        logic [MB_W-1:0]  src_mip_base;
        logic [MC_W-1:0]  src_mip_count;
        logic [ASP_W-1:0] src_aspect;
        logic [LB_W-1:0]  hole_layer_base;
        logic [LC_W-1:0]  hole_layer_count;
        logic [MB_W-1:0]  hole_mip_base;
        logic [MC_W-1:0]  hole_mip_count;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [LB_W-1:0]  piece_layer_base;
        logic [LC_W-1:0]  piece_layer_count;
        logic [MB_W-1:0]  piece_mip_base;
        logic [MC_W-1:0]  piece_mip_count;
        logic [ASP_W-1:0] piece_aspect;
        logic             last_piece;
    } t_out;

    // One piece before aspect and last flag are attached
    typedef struct packed {
        logic [LB_W-1:0] lb;
        logic [LC_W-1:0] lc;
        logic [MB_W-1:0] mb;
        logic [MC_W-1:0] mc;
    } t_piece;

    // Classified item: ordered piece list handed to the back end
    typedef struct packed {
        t_piece [MAX_PIECES-1:0] pieces;
        logic [PCNT_W-1:0]       count;
        logic [ASP_W-1:0]        aspect;
    } t_job;

    // Queue handshake between front and back end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: sv/rsub_front.sv
// ----------------------------------------------------------------------------
// rsub_front
// Accepts input transactions and splits the source range into an ordered
// piece list: layer cuts first, then mip cuts on the piece inside the hole.
// ----------------------------------------------------------------------------
module rsub_front (
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rsub_pkg::t_in        i_item,
    input  rsub_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output rsub_pkg::t_job       o_job
);

    // Layer axis
    logic [rsub_pkg::LSUM_W-1:0] l_sb, l_sc, l_hb, l_hc, l_send, l_hend, l_lo, l_hi;
    logic [rsub_pkg::LSUM_W-1:0] l_left_cnt, l_right_cnt, l_mid_cnt;
    logic                        l_left, l_right, l_inside;

    // Mip axis
    logic [rsub_pkg::MSUM_W-1:0] m_sb, m_sc, m_hb, m_hc, m_send, m_hend, m_lo, m_hi;
    logic [rsub_pkg::MSUM_W-1:0] m_left_cnt, m_right_cnt, m_mid_cnt;
    logic                        m_left, m_right;

    logic                        hole_ok;
    logic [rsub_pkg::PCNT_W-1:0] n;
    rsub_pkg::t_job              job;

    // Handshake: take an item whenever the queue has room
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;
    assign hole_ok = (i_item.hole_layer_count != '0) && (i_item.hole_mip_count != '0);

    // Layer split
    always_comb begin
        l_sb   = rsub_pkg::LSUM_W'(i_item.src_layer_base);
        l_sc   = rsub_pkg::LSUM_W'(i_item.src_layer_count);
        l_hb   = rsub_pkg::LSUM_W'(i_item.hole_layer_base);
        l_hc   = rsub_pkg::LSUM_W'(i_item.hole_layer_count);
        l_send = l_sb + l_sc;
        l_hend = l_hb + l_hc;
        l_left  = hole_ok && (l_hb > l_sb) && (l_hb < l_send);
        l_right = hole_ok && (l_hend > l_sb) && (l_hend < l_send);
        l_lo   = l_left  ? l_hb   : l_sb;
        l_hi   = l_right ? l_hend : l_send;
        l_left_cnt  = l_hb - l_sb;
        l_right_cnt = l_send - l_hend;
        l_mid_cnt   = l_hi - l_lo;
        // only the remainder piece can sit inside the hole's layer span
        l_inside = hole_ok && (l_lo >= l_hb) && (l_hi <= l_hend);
    end

    // Mip split
    always_comb begin
        m_sb   = rsub_pkg::MSUM_W'(i_item.src_mip_base);
        m_sc   = rsub_pkg::MSUM_W'(i_item.src_mip_count);
        m_hb   = rsub_pkg::MSUM_W'(i_item.hole_mip_base);
        m_hc   = rsub_pkg::MSUM_W'(i_item.hole_mip_count);
        m_send = m_sb + m_sc;
        m_hend = m_hb + m_hc;
        m_left  = (m_hb > m_sb) && (m_hb < m_send);
        m_right = (m_hend > m_sb) && (m_hend < m_send);
        m_lo   = m_left  ? m_hb   : m_sb;
        m_hi   = m_right ? m_hend : m_send;
        m_left_cnt  = m_hb - m_sb;
        m_right_cnt = m_send - m_hend;
        m_mid_cnt   = m_hi - m_lo;
    end

    // Compact the pieces in emission order
    always_comb begin
        job        = '0;
        n          = '0;
        job.aspect = i_item.src_aspect;
        if (l_left) begin
            job.pieces[n] = '{lb: i_item.src_layer_base,
                              lc: l_left_cnt[rsub_pkg::LC_W-1:0],
                              mb: i_item.src_mip_base,
                              mc: i_item.src_mip_count};
            n = n + rsub_pkg::PCNT_W'(1);
        end
        if (l_right) begin
            job.pieces[n] = '{lb: l_hend[rsub_pkg::LB_W-1:0],
                              lc: l_right_cnt[rsub_pkg::LC_W-1:0],
                              mb: i_item.src_mip_base,
                              mc: i_item.src_mip_count};
            n = n + rsub_pkg::PCNT_W'(1);
        end
        if (l_inside) begin
            // remainder is cut again along mips
            if (m_left) begin
                job.pieces[n] = '{lb: l_lo[rsub_pkg::LB_W-1:0],
                                  lc: l_mid_cnt[rsub_pkg::LC_W-1:0],
                                  mb: i_item.src_mip_base,
                                  mc: m_left_cnt[rsub_pkg::MC_W-1:0]};
                n = n + rsub_pkg::PCNT_W'(1);
            end
            if (m_right) begin
                job.pieces[n] = '{lb: l_lo[rsub_pkg::LB_W-1:0],
                                  lc: l_mid_cnt[rsub_pkg::LC_W-1:0],
                                  mb: m_hend[rsub_pkg::MB_W-1:0],
                                  mc: m_right_cnt[rsub_pkg::MC_W-1:0]};
                n = n + rsub_pkg::PCNT_W'(1);
            end
            job.pieces[n] = '{lb: l_lo[rsub_pkg::LB_W-1:0],
                              lc: l_mid_cnt[rsub_pkg::LC_W-1:0],
                              mb: m_lo[rsub_pkg::MB_W-1:0],
                              mc: m_mid_cnt[rsub_pkg::MC_W-1:0]};
            n = n + rsub_pkg::PCNT_W'(1);
        end else begin
            job.pieces[n] = '{lb: l_lo[rsub_pkg::LB_W-1:0],
                              lc: l_mid_cnt[rsub_pkg::LC_W-1:0],
                              mb: i_item.src_mip_base,
                              mc: i_item.src_mip_count};
            n = n + rsub_pkg::PCNT_W'(1);
        end
        job.count = n;
    end

    assign o_job = job;

endmodule

// File: sv/rsub_queue.sv
// ----------------------------------------------------------------------------
// rsub_queue
// Two-entry queue of classified items between the front and back end.
// ----------------------------------------------------------------------------
module rsub_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rsub_pkg::t_job       i_job,
    input  logic                 i_pop,
    output rsub_pkg::t_job       o_job,
    output rsub_pkg::t_q_status  o_status
);

    rsub_pkg::t_job r_mem [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr, n_rd_ptr;
    logic [1:0]     n_count;

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

// File: sv/rsub_back.sv
// ----------------------------------------------------------------------------
// rsub_back
// Walks the head item's piece list into the output register, one piece per
// cycle unless stalled, and releases the item when its last piece is loaded.
// ----------------------------------------------------------------------------
module rsub_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsub_pkg::t_job       i_job,
    input  rsub_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rsub_pkg::t_out       o_piece
);

    logic [rsub_pkg::PCNT_W-1:0] r_idx, n_idx;
    logic                        r_valid, n_valid;
    rsub_pkg::t_out              r_piece;
    rsub_pkg::t_piece            sel;
    logic                        load, take, last;

    // Output register accepts a new piece when empty or being drained
    always_comb begin
        load    = !r_valid || !i_stall;
        take    = load && !i_q_status.empty;
        sel     = i_job.pieces[r_idx];
        last    = (r_idx == (i_job.count - rsub_pkg::PCNT_W'(1)));
        o_pop   = take && last;
        n_valid = load ? !i_q_status.empty : r_valid;
        n_idx   = r_idx;
        if (take) begin
            n_idx = last ? '0 : r_idx + rsub_pkg::PCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_piece <= '{piece_layer_base:  sel.lb,
                         piece_layer_count: sel.lc,
                         piece_mip_base:    sel.mb,
                         piece_mip_count:   sel.mc,
                         piece_aspect:      i_job.aspect,
                         last_piece:        last};
        end
    end

    assign o_valid = r_valid;
    assign o_piece = r_piece;

endmodule

// File: sv/subresource_range_subtract.sv
// ----------------------------------------------------------------------------
// subresource_range_subtract
// Cuts a hole range out of a source range in layer-by-mip space.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one source and
//   one hole range per transaction. Output channel (o_out_valid /
//   i_out_stall / o_out_piece) returns one to five disjoint pieces that
//   cover the source; last_piece marks the final piece of each input.
//   Order: left, right, then remainder along layers; the remainder inside
//   the hole's layer span is cut along mips in the same order.
// Path: an accepted input is written into the queue; the back end then loads
//   its first piece from the queue head into the output register, which
//   drives o_out_piece.
// Throughput: one piece per cycle on the output while i_out_stall is low;
//   an item yields 1 to 5 pieces. The front end classifies an item
//   combinationally into a two-entry queue, so input transactions are taken
//   back to back while the queue has room.
// Reset: synchronous, active low; clears the queue and the output valid.
// Stall: a stalled output holds its piece; the queue then fills and
//   o_in_stall rises once both entries are occupied.
// ----------------------------------------------------------------------------
module subresource_range_subtract (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  rsub_pkg::t_in   i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output rsub_pkg::t_out  o_out_piece
);

    rsub_pkg::t_job       front_job, head_job;
    rsub_pkg::t_q_status  q_status;
    logic                 push, pop;

    // Classification
    rsub_front u_front (
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_item     (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (front_job)
    );

    // Decoupling queue
    rsub_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // Piece sequencer and output register
    rsub_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_piece    (o_out_piece)
    );

endmodule
